// ===== rtl/aabb_pkg.sv =====
`timescale 1ns / 1ps
// aabb_pkg: shared widths, types, register codes and saturation helper
// for the aabb_affine_transform block; no dependencies
package aabb_pkg;

    localparam int COORD_BITS     = 16;
    localparam int COEF_FRAC_BITS = 12;

    localparam int COEF_BITS  = 16;
    localparam int TRANS_BITS = 16;
    localparam int ROW_W      = 64;
    localparam int TRANS_LSB  = 48;

    localparam int PROD_W  = COORD_BITS + COEF_BITS;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT_W = SUM_W - COEF_FRAC_BITS;
    localparam int ACC_W   = ((SHIFT_W > TRANS_BITS) ? SHIFT_W : TRANS_BITS) + 1;

    localparam int FIELDS  = 6;
    localparam int DATA_W  = ((FIELDS * COORD_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_Z = 2'd2;

    localparam logic [ROW_W-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 64'h0000_1000_0000_0000;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [2:0][COORD_BITS-1:0]   t_vec3;
    typedef logic [ROW_W-1:0]             t_row;

    typedef struct packed {
        t_row z;
        t_row y;
        t_row x;
    } t_rows;

    function automatic t_coord sat_coord(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        hi_lim = ACC_W'(COORD_MAX);
        lo_lim = ACC_W'(COORD_MIN);
        if (v > hi_lim) begin
            return COORD_MAX;
        end else if (v < lo_lim) begin
            return COORD_MIN;
        end else begin
            return v[COORD_BITS-1:0];
        end
    endfunction

endpackage

// ===== rtl/aabb_cfg.sv =====
`timescale 1ns / 1ps
// aabb_cfg: the three transform row registers and their write port
// depends on aabb_pkg
module aabb_cfg
    import aabb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ROW_W-1:0]      i_cfg_wdata,
    output t_rows                 o_rows
);

    t_rows r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows.x <= ROW_X_RST;
            r_rows.y <= ROW_Y_RST;
            r_rows.z <= ROW_Z_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ROW_X: r_rows.x <= i_cfg_wdata;
                REG_ROW_Y: r_rows.y <= i_cfg_wdata;
                REG_ROW_Z: r_rows.z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_rows = r_rows;

endmodule

// ===== rtl/aabb_axis.sv =====
`timescale 1ns / 1ps
// aabb_axis: one output axis, per-term min/max products, sum, floor shift,
// translation and saturation; depends on aabb_pkg
module aabb_axis
    import aabb_pkg::*;
(
    input  t_row   i_row,
    input  t_vec3  i_lo,
    input  t_vec3  i_hi,
    output t_coord o_min,
    output t_coord o_max
);

    logic signed [PROD_W-1:0] pmin [3];
    logic signed [PROD_W-1:0] pmax [3];
    logic signed [SUM_W-1:0]  smin;
    logic signed [SUM_W-1:0]  smax;
    logic signed [SHIFT_W-1:0] fmin;
    logic signed [SHIFT_W-1:0] fmax;
    logic signed [TRANS_BITS-1:0] trans;

    for (genvar k = 0; k < 3; k++) begin : g_term
        logic signed [COEF_BITS-1:0]  coef;
        logic signed [COORD_BITS-1:0] lo_k;
        logic signed [COORD_BITS-1:0] hi_k;
        logic signed [PROD_W-1:0]     prod_a;
        logic signed [PROD_W-1:0]     prod_b;

        always_comb begin
            coef   = signed'(i_row[COEF_BITS*k +: COEF_BITS]);
            lo_k   = signed'(i_lo[k]);
            hi_k   = signed'(i_hi[k]);
            prod_a = PROD_W'(coef) * PROD_W'(lo_k);
            prod_b = PROD_W'(coef) * PROD_W'(hi_k);
            if (prod_a < prod_b) begin
                pmin[k] = prod_a;
                pmax[k] = prod_b;
            end else begin
                pmin[k] = prod_b;
                pmax[k] = prod_a;
            end
        end
    end

    always_comb begin
        trans = signed'(i_row[TRANS_LSB +: TRANS_BITS]);
        smin  = SUM_W'(pmin[0]) + SUM_W'(pmin[1]) + SUM_W'(pmin[2]);
        smax  = SUM_W'(pmax[0]) + SUM_W'(pmax[1]) + SUM_W'(pmax[2]);
        // arithmetic shift floors toward minus infinity
        fmin  = SHIFT_W'(smin >>> COEF_FRAC_BITS);
        fmax  = SHIFT_W'(smax >>> COEF_FRAC_BITS);
        o_min = sat_coord(ACC_W'(fmin) + ACC_W'(trans));
        o_max = sat_coord(ACC_W'(fmax) + ACC_W'(trans));
    end

endmodule

// ===== rtl/aabb_affine_transform.sv =====
`timescale 1ns / 1ps
// aabb_affine_transform: top level, input register, three axis units,
// result register; depends on aabb_pkg, aabb_cfg, aabb_axis
//
//  channel   direction  handshake                     payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  i_s_axis_tdata (box)
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  o_m_axis_tdata (box)
//  cfg       in         i_cfg_we                      i_cfg_addr, i_cfg_wdata
//
// an accepted item passes the input register, then the result register; one item
// per cycle is sustained while m_axis does not stall
// a stall on m_axis holds the result register; an empty input register still
// takes one more item, after which o_s_axis_tready drops
// reset is synchronous and empties both registers, rows return to identity
module aabb_affine_transform
    import aabb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [DATA_W-1:0]     i_s_axis_tdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [DATA_W-1:0]     o_m_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ROW_W-1:0]      i_cfg_wdata
);

    t_rows rows;
    t_vec3 r_in_lo, r_in_hi;
    logic  r_in_valid;
    t_vec3 r_out_min, r_out_max;
    logic  r_out_valid;
    t_vec3 n_min, n_max;
    logic  out_free;
    logic  in_take;
    logic  advance;

    aabb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rows      (rows)
    );

    aabb_axis u_axis_x (
        .i_row (rows.x), .i_lo (r_in_lo), .i_hi (r_in_hi),
        .o_min (n_min[0]), .o_max (n_max[0])
    );

    aabb_axis u_axis_y (
        .i_row (rows.y), .i_lo (r_in_lo), .i_hi (r_in_hi),
        .o_min (n_min[1]), .o_max (n_max[1])
    );

    aabb_axis u_axis_z (
        .i_row (rows.z), .i_lo (r_in_lo), .i_hi (r_in_hi),
        .o_min (n_min[2]), .o_max (n_max[2])
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (in_take) begin
            r_in_lo <= i_s_axis_tdata[0 +: 3*COORD_BITS];
            r_in_hi <= i_s_axis_tdata[3*COORD_BITS +: 3*COORD_BITS];
        end
        if (advance) begin
            r_out_min <= n_min;
            r_out_max <= n_max;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_W'({r_out_max, r_out_min});

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_axis_tvalid)
        else $error("item lost between input and result register");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (signed'(r_out_min[0]) <= signed'(r_out_max[0])) &&
            (signed'(r_out_min[1]) <= signed'(r_out_max[1])) &&
            (signed'(r_out_min[2]) <= signed'(r_out_max[2])))
        else $error("result box min above max");
`endif

endmodule
